### design/gpio_port_command_unit_core_macros.svh
// Assertion macros for the GPIO port command unit.
// Used by the top level; no other dependencies.
`ifndef GPIO_PORT_COMMAND_UNIT_CORE_MACROS_SVH
`define GPIO_PORT_COMMAND_UNIT_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Check an implication or plain property, disabled in reset.
`define GPCU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gpcu assertion failed");
// Check that a condition never holds, disabled in reset.
`define GPCU_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("gpcu forbidden condition seen");
`else
`define GPCU_ASSERT(label, clk, rst_n, prop)
`define GPCU_NEVER(label, clk, rst_n, cond)
`endif

`endif

### design/gpcu_pkg.sv
// Shared types and constants of the GPIO port command unit.
// No dependencies.
`default_nettype none

package gpcu_pkg;

    localparam int PORT_COUNT = 7;
    localparam int PIN_W      = 16;
    localparam int PORT_W     = 3;
    localparam int CMD_W      = 9;
    localparam int RSV_REGS   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int ADDR_W     = $clog2(PORT_COUNT);

    // Command flag positions
    localparam int CMD_CONFIN  = 0;
    localparam int CMD_CONFOUT = 1;
    localparam int CMD_CONFOD  = 2;
    localparam int CMD_DECONF  = 3;
    localparam int CMD_STORE   = 4;
    localparam int CMD_SET     = 5;
    localparam int CMD_CLEAR   = 6;
    localparam int CMD_INVERT  = 7;
    localparam int CMD_POLL    = 8;

    // Status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_PORT = 1'b1;

    // Per-port state word
    typedef struct packed {
        logic [PIN_W-1:0] cfg;
        logic [PIN_W-1:0] dir;
        logic [PIN_W-1:0] latch;
        logic [PIN_W-1:0] od;
    } t_port_state;

    // State memory access
    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
    } t_mem_req;

    // Port state after reset: nothing configured, every pin an input
    localparam t_port_state PORT_RST = '{
        cfg:   {PIN_W{1'b0}},
        dir:   {PIN_W{1'b1}},
        latch: {PIN_W{1'b0}},
        od:    {PIN_W{1'b0}}
    };

endpackage

`default_nettype wire

### design/gpcu_state_mem.sv
// Per-port state memory, registered read, with per-entry valid bits.
// Depends on gpcu_pkg.
`default_nettype none

module gpcu_state_mem
    import gpcu_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_mem_req    i_req,
    input  t_port_state i_wdata,
    output t_port_state o_rdata
);

    t_port_state             r_mem [PORT_COUNT];
    logic [PORT_COUNT-1:0]   r_vld;
    t_port_state             r_rdata;
    logic                    r_rvld;

    // Write the entry
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_wdata;
        end
    end

    // Mark written entries valid; reset invalidates all
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[i_req.waddr] <= 1'b1;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvld <= 1'b0;
        end else if (i_req.re) begin
            r_rvld <= r_vld[i_req.raddr];
        end
    end

    // An unwritten entry reads as the reset state
    assign o_rdata = r_rvld ? r_rdata : PORT_RST;

endmodule

`default_nettype wire

### design/gpcu_cmd_alu.sv
// Command logic: applies the flagged commands, in fixed order, to one port.
// Depends on gpcu_pkg.
`default_nettype none

module gpcu_cmd_alu
    import gpcu_pkg::*;
(
    input  t_port_state      i_state,
    input  wire [CMD_W-1:0]  i_cmd,
    input  wire [PIN_W-1:0]  i_mask,
    input  wire [PIN_W-1:0]  i_levels,
    output t_port_state      o_state,
    output logic [PIN_W-1:0] o_read_value
);

    always_comb begin
        t_port_state st;
        st = i_state;

        // Configure as input, output, open-drain output
        if (i_cmd[CMD_CONFIN]) begin
            st.dir = st.dir | i_mask;
            st.cfg = st.cfg | i_mask;
        end
        if (i_cmd[CMD_CONFOUT]) begin
            st.od  = st.od & ~i_mask;
            st.dir = st.dir & ~i_mask;
            st.cfg = st.cfg | i_mask;
        end
        if (i_cmd[CMD_CONFOD]) begin
            st.od  = st.od | i_mask;
            st.dir = st.dir & ~i_mask;
            st.cfg = st.cfg | i_mask;
        end
        // Deconfigure
        if (i_cmd[CMD_DECONF]) begin
            st.cfg = st.cfg & ~i_mask;
        end
        // Latch updates act only on configured pins
        if (i_cmd[CMD_STORE]) begin
            st.latch = (st.latch & ~st.cfg) | (i_mask & st.cfg);
        end
        if (i_cmd[CMD_SET]) begin
            st.latch = st.latch | (i_mask & st.cfg);
        end
        if (i_cmd[CMD_CLEAR]) begin
            st.latch = st.latch & ~(i_mask & st.cfg);
        end
        if (i_cmd[CMD_INVERT]) begin
            st.latch = st.latch ^ (i_mask & st.cfg);
        end
        o_state = st;
    end

    // Poll
    assign o_read_value = i_cmd[CMD_POLL] ? i_levels : {PIN_W{1'b0}};

endmodule

`default_nettype wire

### design/gpio_port_command_unit_core.sv
// GPIO port command unit: seven ports, reserved-pin filter, state in one memory.
// A request is captured with its memory read; in S_CALC the result enters the output
// register and the addressed port word is written back. One request is in flight at a
// time, until that write-back; a stalled output holds the write-back stage.
// Reset (synchronous, active low): reserved pins cleared, all port entries
// invalidated so each reads as unconfigured with every pin an input.
`default_nettype none
`include "gpio_port_command_unit_core_macros.svh"

module gpio_port_command_unit_core
    import gpcu_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // Request channel
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire [PORT_W-1:0]     i_port_index,
    input  wire [CMD_W-1:0]      i_command_flags,
    input  wire [PIN_W-1:0]      i_pin_mask,
    input  wire [PIN_W-1:0]      i_pin_levels,
    // Result channel
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic                 o_status,
    output logic [PIN_W-1:0]     o_read_value,
    output logic [PIN_W-1:0]     o_direction_out,
    output logic [PIN_W-1:0]     o_latch_out,
    output logic [PIN_W-1:0]     o_open_drain_out,
    // Configuration write channel
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [PIN_W-1:0]      i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CALC = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [PIN_W-1:0] r_rsv [RSV_REGS];
    logic [PORT_W-1:0] r_port;
    logic [CMD_W-1:0] r_cmd;
    logic [PIN_W-1:0] r_mask;
    logic [PIN_W-1:0] r_levels;
    logic             r_err;
    logic             r_out_valid;
    logic             r_status;
    logic [PIN_W-1:0] r_read;
    logic [PIN_W-1:0] r_dir;
    logic [PIN_W-1:0] r_latch;
    logic [PIN_W-1:0] r_od;

    logic             in_accept;
    logic             port_ok;
    logic [PIN_W-1:0] rsv_sel;
    logic             calc_done;
    t_mem_req         mem_req;
    t_port_state      mem_rdata;
    t_port_state      alu_state;
    logic [PIN_W-1:0] alu_read;

    assign o_cfg_ready = 1'b1;

    // Reserved-pin registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RSV_REGS; k++) begin
                r_rsv[k] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready &&
                     (i_cfg_index < CFG_IDX_W'(RSV_REGS))) begin
            r_rsv[i_cfg_index] <= i_cfg_data;
        end
    end

    // Accept a request only when no other is in flight
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign port_ok    = (i_port_index < PORT_W'(PORT_COUNT));
    assign rsv_sel    = port_ok ? r_rsv[i_port_index] : {PIN_W{1'b0}};

    // Write-back may proceed once the output register can take the result
    assign calc_done  = (r_state == S_CALC) && (!r_out_valid || !i_out_stall);

    // Control
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (calc_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request with its filtered mask
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_port   <= i_port_index;
            r_cmd    <= i_command_flags;
            r_mask   <= i_pin_mask & ~rsv_sel;
            r_levels <= i_pin_levels;
            r_err    <= !port_ok;
        end
    end

    // Memory: read on accept of a valid port, write back when a valid port's result enters the output register
    always_comb begin
        mem_req.re    = in_accept && port_ok;
        mem_req.raddr = i_port_index[ADDR_W-1:0];
        mem_req.we    = calc_done && !r_err;
        mem_req.waddr = r_port[ADDR_W-1:0];
    end

    gpcu_state_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .i_wdata (alu_state),
        .o_rdata (mem_rdata)
    );

    gpcu_cmd_alu u_alu (
        .i_state      (mem_rdata),
        .i_cmd        (r_cmd),
        .i_mask       (r_mask),
        .i_levels     (r_levels),
        .o_state      (alu_state),
        .o_read_value (alu_read)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (calc_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (calc_done) begin
            if (r_err) begin
                r_status <= STATUS_NO_PORT;
                r_read   <= '0;
                r_dir    <= '0;
                r_latch  <= '0;
                r_od     <= '0;
            end else begin
                r_status <= STATUS_OK;
                r_read   <= alu_read;
                r_dir    <= alu_state.dir;
                r_latch  <= alu_state.latch;
                r_od     <= alu_state.od;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_read_value     = r_read;
    assign o_direction_out  = r_dir;
    assign o_latch_out      = r_latch;
    assign o_open_drain_out = r_od;

    // Checks
    `GPCU_ASSERT(a_accept_to_calc, i_clk, i_rst_n, in_accept |=> (r_state == S_CALC))
    `GPCU_NEVER(a_no_write_on_error, i_clk, i_rst_n, mem_req.we && r_err)
    `GPCU_ASSERT(a_write_only_in_calc, i_clk, i_rst_n, mem_req.we |-> (r_state == S_CALC))
    `GPCU_ASSERT(a_error_zero, i_clk, i_rst_n, (r_out_valid && (r_status == STATUS_NO_PORT)) |-> ((r_dir == '0) && (r_latch == '0) && (r_od == '0) && (r_read == '0)))

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for gpio_port_command_unit_core.
// Depends on gpcu_pkg and the core RTL; predicts each result from its own port model.

module tb_top;
    import gpcu_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASE_REQUESTS = 200;

    // Command flag words
    localparam logic [CMD_W-1:0] F_NONE    = '0;
    localparam logic [CMD_W-1:0] F_CONFIN  = CMD_W'(1 << CMD_CONFIN);
    localparam logic [CMD_W-1:0] F_CONFOUT = CMD_W'(1 << CMD_CONFOUT);
    localparam logic [CMD_W-1:0] F_CONFOD  = CMD_W'(1 << CMD_CONFOD);
    localparam logic [CMD_W-1:0] F_DECONF  = CMD_W'(1 << CMD_DECONF);
    localparam logic [CMD_W-1:0] F_STORE   = CMD_W'(1 << CMD_STORE);
    localparam logic [CMD_W-1:0] F_SET     = CMD_W'(1 << CMD_SET);
    localparam logic [CMD_W-1:0] F_CLEAR   = CMD_W'(1 << CMD_CLEAR);
    localparam logic [CMD_W-1:0] F_INVERT  = CMD_W'(1 << CMD_INVERT);
    localparam logic [CMD_W-1:0] F_POLL    = CMD_W'(1 << CMD_POLL);
    localparam logic [CMD_W-1:0] F_ALL     = '1;

    // Reserved-pin register indexes; the last one is past the list
    localparam logic [CFG_IDX_W-1:0] REG_RSV_PORT_A = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RSV_PORT_C = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = CFG_IDX_W'(RSV_REGS);

    localparam logic [PORT_W-1:0] MISSING_PORT = PORT_W'(PORT_COUNT);

    typedef struct packed {
        logic             status;
        logic [PIN_W-1:0] read_value;
        logic [PIN_W-1:0] direction;
        logic [PIN_W-1:0] latch;
        logic [PIN_W-1:0] open_drain;
    } t_port_result;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              req_valid = 1'b0;
    logic [PORT_W-1:0] req_port = '0;
    logic [CMD_W-1:0]  req_flags = '0;
    logic [PIN_W-1:0]  req_mask = '0;
    logic [PIN_W-1:0]  req_levels = '0;
    logic              res_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PIN_W-1:0]     cfg_data = '0;

    wire             req_stall;
    wire             res_valid;
    wire             res_status;
    wire [PIN_W-1:0] res_read_value;
    wire [PIN_W-1:0] res_direction;
    wire [PIN_W-1:0] res_latch;
    wire [PIN_W-1:0] res_open_drain;
    wire             cfg_ready;

    // Port model and the results it expects, oldest first
    t_port_state      port_model [PORT_COUNT];
    logic [PIN_W-1:0] reserved_model [RSV_REGS];
    t_port_result     expected_results [$];

    int mismatch_count = 0;
    int requests_sent = 0;
    int missing_port_requests = 0;
    int results_seen = 0;
    int config_writes = 0;
    int quiet_cycles = 0;

    // Receiver stall pattern state
    bit hold_request = 1'b0;
    int hold_left = 0;
    int seg_left = 0;
    bit seg_stall = 1'b0;

    gpio_port_command_unit_core u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (req_valid),
        .o_in_stall       (req_stall),
        .i_port_index     (req_port),
        .i_command_flags  (req_flags),
        .i_pin_mask       (req_mask),
        .i_pin_levels     (req_levels),
        .o_out_valid      (res_valid),
        .i_out_stall      (res_stall),
        .o_status         (res_status),
        .o_read_value     (res_read_value),
        .o_direction_out  (res_direction),
        .o_latch_out      (res_latch),
        .o_open_drain_out (res_open_drain),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one request to the port model and return the result it should produce
    function automatic t_port_result apply_port_command(logic [PORT_W-1:0] port,
                                                        logic [CMD_W-1:0] flags,
                                                        logic [PIN_W-1:0] mask,
                                                        logic [PIN_W-1:0] levels);
        t_port_result     r;
        t_port_state      s;
        logic [PIN_W-1:0] m;
        logic [PIN_W-1:0] hit;
        r = '0;
        if (port >= PORT_COUNT) begin
            r.status = STATUS_NO_PORT;
            return r;
        end
        s = port_model[port];
        m = mask;
        if (port < RSV_REGS) begin
            m = m & ~reserved_model[port];
        end
        if (flags[CMD_CONFIN]) begin
            s.dir = s.dir | m;
            s.cfg = s.cfg | m;
        end
        if (flags[CMD_CONFOUT]) begin
            s.od  = s.od & ~m;
            s.dir = s.dir & ~m;
            s.cfg = s.cfg | m;
        end
        if (flags[CMD_CONFOD]) begin
            s.od  = s.od | m;
            s.dir = s.dir & ~m;
            s.cfg = s.cfg | m;
        end
        if (flags[CMD_DECONF]) begin
            s.cfg = s.cfg & ~m;
        end
        // Latch commands only touch configured pins
        hit = m & s.cfg;
        if (flags[CMD_STORE]) begin
            s.latch = (s.latch & ~s.cfg) | hit;
        end
        if (flags[CMD_SET]) begin
            s.latch = s.latch | hit;
        end
        if (flags[CMD_CLEAR]) begin
            s.latch = s.latch & ~hit;
        end
        if (flags[CMD_INVERT]) begin
            s.latch = s.latch ^ hit;
        end
        if (flags[CMD_POLL]) begin
            r.read_value = levels;
        end
        port_model[port] = s;
        r.status     = STATUS_OK;
        r.direction  = s.dir;
        r.latch      = s.latch;
        r.open_drain = s.od;
        return r;
    endfunction

    function automatic logic [PIN_W-1:0] pick_mask();
        logic [PIN_W-1:0] v;
        v = PIN_W'($urandom);
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = PIN_W'(1 << $urandom_range(0, PIN_W - 1));
            3: v = v & PIN_W'($urandom);
            default: ;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(string text);
        $display("mismatch: %s", text);
        mismatch_count++;
    endtask

    // Send one request and record what it should produce once accepted
    task automatic send_request(logic [PORT_W-1:0] port, logic [CMD_W-1:0] flags,
                                logic [PIN_W-1:0] mask, logic [PIN_W-1:0] levels);
        @(negedge clk);
        req_valid  <= 1'b1;
        req_port   <= port;
        req_flags  <= flags;
        req_mask   <= mask;
        req_levels <= levels;
        do @(posedge clk); while (req_stall !== 1'b0);
        expected_results.push_back(apply_port_command(port, flags, mask, levels));
        requests_sent++;
        if (port >= PORT_COUNT) begin
            missing_port_requests++;
        end
    endtask

    task automatic idle_requests(int cycles);
        repeat (cycles) begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
    endtask

    // Drop the request line and hold until every expected result is back
    task automatic wait_results_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [PIN_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        if (index < RSV_REGS) begin
            reserved_model[index] = data;
        end
        config_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        // No flags shows the reset registers; poll alone reads the levels
        send_request(PORT_W'(0), F_NONE, 16'hffff, 16'hffff);
        send_request(PORT_W'(PORT_COUNT - 1), F_POLL, 16'h0000, 16'ha5a5);
        wait_results_drained();
    endtask

    task automatic test_each_command();
        send_request(PORT_W'(1), F_CONFOUT, 16'hffff, 16'h0000);
        send_request(PORT_W'(1), F_STORE, 16'h1234, 16'h0000);
        send_request(PORT_W'(1), F_SET, 16'h00f0, 16'h0000);
        send_request(PORT_W'(1), F_CLEAR, 16'h0030, 16'h0000);
        send_request(PORT_W'(1), F_INVERT, 16'hffff, 16'hffff);
        send_request(PORT_W'(1), F_CONFOD, 16'hff00, 16'h0000);
        send_request(PORT_W'(1), F_CONFIN, 16'h000f, 16'h0000);
        send_request(PORT_W'(1), F_DECONF, 16'h00ff, 16'h0000);
        send_request(PORT_W'(1), F_STORE, 16'h0000, 16'h0000);
        send_request(PORT_W'(1), F_POLL, 16'h0000, 16'hffff);
        send_request(PORT_W'(3), F_ALL, 16'hffff, 16'h5a5a);
        send_request(PORT_W'(4), F_ALL, 16'h0000, 16'h0000);
        wait_results_drained();
    endtask

    task automatic test_reserved_filter();
        write_register(REG_RSV_PORT_C, 16'h00ff);
        send_request(PORT_W'(2), F_CONFOUT | F_STORE, 16'hffff, 16'h0000);
        send_request(PORT_W'(2), F_INVERT, 16'hffff, 16'h0000);
        wait_results_drained();
        // Fully reserved port: every command sees an empty mask
        write_register(REG_RSV_PORT_C, 16'hffff);
        send_request(PORT_W'(2), F_CONFIN | F_SET | F_POLL, 16'hffff, 16'h8001);
        wait_results_drained();
        write_register(REG_RSV_PORT_C, 16'h0000);
    endtask

    task automatic test_missing_port();
        send_request(MISSING_PORT, F_ALL, 16'hffff, 16'hffff);
        send_request(MISSING_PORT, F_NONE, 16'h0000, 16'h0000);
        send_request(PORT_W'(5), F_POLL, 16'h0000, 16'h0ff0);
        wait_results_drained();
    endtask

    // Mostly configure-then-drive sequences on one port, with some noise
    task automatic send_random_requests(int count);
        int               sent;
        int               burst;
        int               seq_left;
        logic [PORT_W-1:0] seq_port;
        logic [PORT_W-1:0] port;
        logic [CMD_W-1:0]  flags;
        sent = 0;
        seq_left = 0;
        seq_port = '0;
        while (sent < count) begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 10);
            repeat (burst) begin
                if (seq_left == 0 && $urandom_range(0, 4) == 0) begin
                    port  = PORT_W'($urandom_range(0, 7));
                    flags = CMD_W'($urandom_range(0, 511));
                end else begin
                    if (seq_left == 0) begin
                        seq_port = PORT_W'($urandom_range(0, PORT_COUNT - 1));
                        seq_left = $urandom_range(2, 6);
                        case ($urandom_range(0, 2))
                            0: flags = F_CONFIN;
                            1: flags = F_CONFOUT;
                            default: flags = F_CONFOD;
                        endcase
                        if ($urandom_range(0, 1) == 1) begin
                            flags = flags | F_STORE;
                        end
                    end else begin
                        seq_left--;
                        case ($urandom_range(0, 6))
                            0: flags = F_STORE;
                            1: flags = F_SET;
                            2: flags = F_CLEAR;
                            3: flags = F_INVERT;
                            4: flags = F_POLL;
                            5: flags = F_DECONF;
                            default: begin
                                flags = CMD_W'($urandom_range(0, 511));
                                flags = flags & (F_STORE | F_SET | F_CLEAR | F_INVERT);
                            end
                        endcase
                        if ($urandom_range(0, 3) == 0) begin
                            flags = flags | F_POLL;
                        end
                    end
                    port = seq_port;
                end
                send_request(port, flags, pick_mask(), PIN_W'($urandom));
                sent++;
            end
            if ($urandom_range(0, 2) != 0) begin
                idle_requests($urandom_range(1, 6));
            end
        end
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int i;
        // All pins free
        send_random_requests(PHASE_REQUESTS);
        // Independent random reservations
        for (i = 0; i < RSV_REGS; i++) begin
            write_register(REG_RSV_PORT_A + CFG_IDX_W'(i), PIN_W'($urandom));
        end
        send_random_requests(PHASE_REQUESTS);
        // Extremes, plus a write past the register list
        for (i = 0; i < RSV_REGS; i++) begin
            write_register(REG_RSV_PORT_A + CFG_IDX_W'(i),
                           (i % 2 == 0) ? 16'hffff : 16'h0000);
        end
        write_register(REG_UNUSED, 16'hffff);
        send_random_requests(PHASE_REQUESTS);
        // Sparse reservations
        for (i = 0; i < RSV_REGS; i++) begin
            write_register(REG_RSV_PORT_A + CFG_IDX_W'(i), PIN_W'($urandom & $urandom));
        end
        send_random_requests(PHASE_REQUESTS);
    endtask

    // Hold results off long enough that the core backs up into the request side
    task automatic test_backpressure();
        int i;
        hold_request = 1'b1;
        for (i = 0; i < 40; i++) begin
            send_request(PORT_W'($urandom_range(0, PORT_COUNT - 1)),
                         CMD_W'($urandom_range(0, 511)),
                         pick_mask(), PIN_W'($urandom));
        end
        wait_results_drained();
    endtask

    // Receiver stall pattern: free stretches, short stalls, toggling, one long hold
    always @(negedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else if (hold_left > 0) begin
            res_stall <= 1'b1;
            hold_left--;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            res_stall <= 1'b1;
        end else begin
            if (seg_left == 0) begin
                case ($urandom_range(0, 3))
                    0: begin
                        seg_stall = 1'b0;
                        seg_left = $urandom_range(20, 60);
                    end
                    1: begin
                        seg_stall = 1'b1;
                        seg_left = $urandom_range(1, 5);
                    end
                    default: begin
                        seg_stall = ~seg_stall;
                        seg_left = $urandom_range(1, 4);
                    end
                endcase
            end
            res_stall <= seg_stall;
            seg_left--;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk) begin : result_check
        t_port_result want;
        if (rst_n && res_valid === 1'b1 && res_stall == 1'b0) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            end else begin
                want = expected_results.pop_front();
                if (res_status !== want.status)
                    report_mismatch($sformatf("result %0d status got %h want %h",
                                              results_seen, res_status, want.status));
                if (res_read_value !== want.read_value)
                    report_mismatch($sformatf("result %0d read_value got %h want %h",
                                              results_seen, res_read_value,
                                              want.read_value));
                if (res_direction !== want.direction)
                    report_mismatch($sformatf("result %0d direction got %h want %h",
                                              results_seen, res_direction,
                                              want.direction));
                if (res_latch !== want.latch)
                    report_mismatch($sformatf("result %0d latch got %h want %h",
                                              results_seen, res_latch, want.latch));
                if (res_open_drain !== want.open_drain)
                    report_mismatch($sformatf("result %0d open_drain got %h want %h",
                                              results_seen, res_open_drain,
                                              want.open_drain));
            end
            results_seen++;
        end
    end

    // End the run if no handshake of any kind completes for too long
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_stall === 1'b0) ||
            (res_valid === 1'b1 && !res_stall) || (cfg_valid && cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int i;
        for (i = 0; i < PORT_COUNT; i++) begin
            port_model[i] = PORT_RST;
        end
        for (i = 0; i < RSV_REGS; i++) begin
            reserved_model[i] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_each_command();
        test_reserved_filter();
        test_missing_port();
        test_random_traffic();
        test_backpressure();
        wait_results_drained();

        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
        $display("summary: %0d requests (%0d to the missing port), %0d results checked",
                 requests_sent, missing_port_requests, results_seen);
        $display("summary: %0d register writes over five reserved-pin settings, %0d mismatches",
                 config_writes, mismatch_count);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
